// File: sv/upq_pkg.sv
// Shared constants, types and helper functions for the urgent-first priority queue.
`timescale 1ns / 1ps
package upq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF    = 16;
	localparam int TIME_BITS       = 32;
	localparam int KIND_BITS       = 2;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [KIND_BITS-1:0] KIND_SYSTEM  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_MESSAGE = 2'd1;

	localparam logic [1:0] RANK_URGENT  = 2'd3;
	localparam logic [1:0] RANK_MESSAGE = 2'd2;
	localparam logic [1:0] RANK_SYSTEM  = 2'd1;
	localparam logic [1:0] RANK_OTHER   = 2'd0;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REMOVE,
		S_OUT
	} fsm_state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic active;
	} cell_ctrl_t;

	function automatic logic is_urgent_sys(input logic [KIND_BITS-1:0] kind, input logic urgent);
		return (kind == KIND_SYSTEM) && urgent;
	endfunction

	function automatic logic [1:0] rank_of(input logic [KIND_BITS-1:0] kind, input logic urgent);
		logic [1:0] r;
		if (is_urgent_sys(kind, urgent)) begin
			r = RANK_URGENT;
		end else if (kind == KIND_MESSAGE) begin
			r = RANK_MESSAGE;
		end else if (kind == KIND_SYSTEM) begin
			r = RANK_SYSTEM;
		end else begin
			r = RANK_OTHER;
		end
		return r;
	endfunction

endpackage

// File: sv/urgent_first_priority_queue_unit.sv
// Top level of the urgent-first priority queue: control, cell chain and result register.
// Push and failed pop: result in the cycle after the input beat, next beat in the cycle after.
// Pop: the best entry ripples through the cell chain in S_SCAN, S_REMOVE removes it and
// closes the gap, then S_OUT holds the result until it is taken.
// One beat at a time; the next input beat is taken once the result beat has left.
// Reset (arst_n low) empties the queue and clears control; slot contents stay unknown.
`timescale 1ns / 1ps
module urgent_first_priority_queue_unit #(
	parameter int QUEUE_DEPTH = upq_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = upq_pkg::TAG_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  func,
	input  logic [upq_pkg::TIME_BITS-1:0]         entry_time,
	input  logic [upq_pkg::KIND_BITS-1:0]         entry_kind,
	input  logic                                  entry_urgent,
	input  logic [TAG_BITS-1:0]                   entry_tag,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            status,
	output logic [upq_pkg::TIME_BITS-1:0]         out_time,
	output logic [upq_pkg::KIND_BITS-1:0]         out_kind,
	output logic                                  out_urgent,
	output logic [TAG_BITS-1:0]                   out_tag,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]      occupancy
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(QUEUE_DEPTH - 1);

	upq_pkg::fsm_state_t state_q, state_d;
	logic [CNT_W-1:0]    fill_q;
	logic [IDX_W-1:0]    cnt_q;

	upq_pkg::status_t              status_q;
	logic [upq_pkg::TIME_BITS-1:0] otime_q;
	logic [upq_pkg::KIND_BITS-1:0] okind_q;
	logic                          ourgent_q;
	logic [TAG_BITS-1:0]           otag_q;
	logic [CNT_W-1:0]              occ_q;

	logic acc;
	logic do_push;
	logic do_remove;

	logic [upq_pkg::TIME_BITS-1:0] c_time   [QUEUE_DEPTH];
	logic [upq_pkg::KIND_BITS-1:0] c_kind   [QUEUE_DEPTH];
	logic                          c_urgent [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]           c_tag    [QUEUE_DEPTH];

	logic                          w_valid  [QUEUE_DEPTH+1];
	logic [upq_pkg::TIME_BITS-1:0] w_time   [QUEUE_DEPTH+1];
	logic [upq_pkg::KIND_BITS-1:0] w_kind   [QUEUE_DEPTH+1];
	logic                          w_urgent [QUEUE_DEPTH+1];
	logic [TAG_BITS-1:0]           w_tag    [QUEUE_DEPTH+1];
	logic [IDX_W-1:0]              w_idx    [QUEUE_DEPTH+1];

	upq_pkg::cell_ctrl_t ctrl [QUEUE_DEPTH];

	assign acc = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			upq_pkg::S_IDLE: begin
				if (acc) begin
					if (func == upq_pkg::FUNC_POP && fill_q != '0) begin
						state_d = upq_pkg::S_SCAN;
					end else begin
						state_d = upq_pkg::S_OUT;
					end
				end
			end
			upq_pkg::S_SCAN: begin
				if (cnt_q == SCAN_END) begin
					state_d = upq_pkg::S_REMOVE;
				end
			end
			upq_pkg::S_REMOVE: begin
				state_d = upq_pkg::S_OUT;
			end
			upq_pkg::S_OUT: begin
				if (out_ready) begin
					state_d = upq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = upq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = state_q == upq_pkg::S_IDLE;
		out_valid = state_q == upq_pkg::S_OUT;
		do_push   = acc && func == upq_pkg::FUNC_PUSH && fill_q < DEPTH_C;
		do_remove = state_q == upq_pkg::S_REMOVE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= upq_pkg::S_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (do_push) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_remove) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (state_q == upq_pkg::S_SCAN) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			otime_q   <= '0;
			okind_q   <= '0;
			ourgent_q <= 1'b0;
			otag_q    <= '0;
			if (func == upq_pkg::FUNC_PUSH) begin
				if (fill_q < DEPTH_C) begin
					status_q <= upq_pkg::ST_PUSHED;
					occ_q    <= fill_q + CNT_W'(1);
				end else begin
					status_q <= upq_pkg::ST_FULL;
					occ_q    <= fill_q;
				end
			end else begin
				status_q <= upq_pkg::ST_EMPTY;
				occ_q    <= fill_q;
			end
		end else if (do_remove) begin
			status_q  <= upq_pkg::ST_POPPED;
			otime_q   <= w_time[QUEUE_DEPTH];
			okind_q   <= w_kind[QUEUE_DEPTH];
			ourgent_q <= w_urgent[QUEUE_DEPTH];
			otag_q    <= w_tag[QUEUE_DEPTH];
			occ_q     <= fill_q - CNT_W'(1);
		end
	end

	assign w_valid[0]  = 1'b0;
	assign w_time[0]   = '0;
	assign w_kind[0]   = '0;
	assign w_urgent[0] = 1'b0;
	assign w_tag[0]    = '0;
	assign w_idx[0]    = '0;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		localparam logic [CNT_W-1:0] K_C  = CNT_W'(k);
		localparam logic [CNT_W-1:0] K1_C = CNT_W'(k + 1);

		logic [upq_pkg::TIME_BITS-1:0] n_time;
		logic [upq_pkg::KIND_BITS-1:0] n_kind;
		logic                          n_urgent;
		logic [TAG_BITS-1:0]           n_tag;

		if (k < QUEUE_DEPTH - 1) begin : g_mid
			assign n_time   = c_time[k+1];
			assign n_kind   = c_kind[k+1];
			assign n_urgent = c_urgent[k+1];
			assign n_tag    = c_tag[k+1];
		end else begin : g_last
			assign n_time   = c_time[k];
			assign n_kind   = c_kind[k];
			assign n_urgent = c_urgent[k];
			assign n_tag    = c_tag[k];
		end

		always_comb begin
			ctrl[k].load   = do_push && fill_q == K_C;
			ctrl[k].shift  = do_remove && K_C >= CNT_W'(w_idx[QUEUE_DEPTH]) && K1_C < fill_q;
			ctrl[k].active = K_C < fill_q;
		end

		upq_cell #(
			.QUEUE_DEPTH (QUEUE_DEPTH),
			.TAG_BITS    (TAG_BITS),
			.CELL_IDX    (k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl[k]),
			.push_time   (entry_time),
			.push_kind   (entry_kind),
			.push_urgent (entry_urgent),
			.push_tag    (entry_tag),
			.nxt_time    (n_time),
			.nxt_kind    (n_kind),
			.nxt_urgent  (n_urgent),
			.nxt_tag     (n_tag),
			.cur_time    (c_time[k]),
			.cur_kind    (c_kind[k]),
			.cur_urgent  (c_urgent[k]),
			.cur_tag     (c_tag[k]),
			.prv_valid   (w_valid[k]),
			.prv_time    (w_time[k]),
			.prv_kind    (w_kind[k]),
			.prv_urgent  (w_urgent[k]),
			.prv_tag     (w_tag[k]),
			.prv_idx     (w_idx[k]),
			.win_valid   (w_valid[k+1]),
			.win_time    (w_time[k+1]),
			.win_kind    (w_kind[k+1]),
			.win_urgent  (w_urgent[k+1]),
			.win_tag     (w_tag[k+1]),
			.win_idx     (w_idx[k+1])
		);
	end

	assign status     = status_q;
	assign out_time   = otime_q;
	assign out_kind   = okind_q;
	assign out_urgent = ourgent_q;
	assign out_tag    = otag_q;
	assign occupancy  = occ_q;

endmodule

// File: sv/upq_cell.sv
// One queue slot: holds an entry and forwards the best entry seen so far down the chain.
`timescale 1ns / 1ps
module upq_cell #(
	parameter int QUEUE_DEPTH = upq_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = upq_pkg::TAG_BITS_DEF,
	parameter int CELL_IDX    = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  upq_pkg::cell_ctrl_t                   ctrl,
	input  logic [upq_pkg::TIME_BITS-1:0]         push_time,
	input  logic [upq_pkg::KIND_BITS-1:0]         push_kind,
	input  logic                                  push_urgent,
	input  logic [TAG_BITS-1:0]                   push_tag,
	input  logic [upq_pkg::TIME_BITS-1:0]         nxt_time,
	input  logic [upq_pkg::KIND_BITS-1:0]         nxt_kind,
	input  logic                                  nxt_urgent,
	input  logic [TAG_BITS-1:0]                   nxt_tag,
	output logic [upq_pkg::TIME_BITS-1:0]         cur_time,
	output logic [upq_pkg::KIND_BITS-1:0]         cur_kind,
	output logic                                  cur_urgent,
	output logic [TAG_BITS-1:0]                   cur_tag,
	input  logic                                  prv_valid,
	input  logic [upq_pkg::TIME_BITS-1:0]         prv_time,
	input  logic [upq_pkg::KIND_BITS-1:0]         prv_kind,
	input  logic                                  prv_urgent,
	input  logic [TAG_BITS-1:0]                   prv_tag,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]        prv_idx,
	output logic                                  win_valid,
	output logic [upq_pkg::TIME_BITS-1:0]         win_time,
	output logic [upq_pkg::KIND_BITS-1:0]         win_kind,
	output logic                                  win_urgent,
	output logic [TAG_BITS-1:0]                   win_tag,
	output logic [$clog2(QUEUE_DEPTH)-1:0]        win_idx
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [upq_pkg::TIME_BITS-1:0] time_q;
	logic [upq_pkg::KIND_BITS-1:0] kind_q;
	logic                          urgent_q;
	logic [TAG_BITS-1:0]           tag_q;

	logic                          win_valid_q;
	logic [upq_pkg::TIME_BITS-1:0] win_time_q;
	logic [upq_pkg::KIND_BITS-1:0] win_kind_q;
	logic                          win_urgent_q;
	logic [TAG_BITS-1:0]           win_tag_q;
	logic [IDX_W-1:0]              win_idx_q;

	logic own_us;
	logic prv_us;
	logic beats;
	logic take_own;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			time_q   <= push_time;
			kind_q   <= push_kind;
			urgent_q <= push_urgent;
			tag_q    <= push_tag;
		end else if (ctrl.shift) begin
			time_q   <= nxt_time;
			kind_q   <= nxt_kind;
			urgent_q <= nxt_urgent;
			tag_q    <= nxt_tag;
		end
	end

	always_comb begin
		own_us = upq_pkg::is_urgent_sys(kind_q, urgent_q);
		prv_us = upq_pkg::is_urgent_sys(prv_kind, prv_urgent);
		if (own_us != prv_us) begin
			beats = own_us;
		end else if (time_q != prv_time) begin
			beats = time_q < prv_time;
		end else begin
			beats = upq_pkg::rank_of(kind_q, urgent_q) > upq_pkg::rank_of(prv_kind, prv_urgent);
		end
		take_own = ctrl.active && (!prv_valid || beats);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
		end else begin
			win_valid_q <= ctrl.active || prv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_own) begin
			win_time_q   <= time_q;
			win_kind_q   <= kind_q;
			win_urgent_q <= urgent_q;
			win_tag_q    <= tag_q;
			win_idx_q    <= MY_IDX;
		end else begin
			win_time_q   <= prv_time;
			win_kind_q   <= prv_kind;
			win_urgent_q <= prv_urgent;
			win_tag_q    <= prv_tag;
			win_idx_q    <= prv_idx;
		end
	end

	assign cur_time   = time_q;
	assign cur_kind   = kind_q;
	assign cur_urgent = urgent_q;
	assign cur_tag    = tag_q;

	assign win_valid  = win_valid_q;
	assign win_time   = win_time_q;
	assign win_kind   = win_kind_q;
	assign win_urgent = win_urgent_q;
	assign win_tag    = win_tag_q;
	assign win_idx    = win_idx_q;

endmodule

// File: dv/tb_urgent_first_priority_queue_unit.sv
// Testbench for the urgent-first priority queue: directed and random traffic checked against a queue predictor.
`timescale 1ns / 1ps
module tb_urgent_first_priority_queue_unit;

	localparam int DEPTH         = upq_pkg::QUEUE_DEPTH_DEF;
	localparam int TAG_W         = upq_pkg::TAG_BITS_DEF;
	localparam int TIME_W        = upq_pkg::TIME_BITS;
	localparam int KIND_W        = upq_pkg::KIND_BITS;
	localparam int OCC_W         = $clog2(DEPTH + 1);
	localparam int SETTLE_CYCLES = DEPTH + 4;

	localparam logic [KIND_W-1:0] KIND_APP   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [KIND_W-1:0] kind;
		logic              urgent;
		logic [TAG_W-1:0]  tag;
	} note_t;

	typedef struct packed {
		logic [1:0]       st;
		note_t            note;
		logic [OCC_W-1:0] occ;
	} outcome_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              func;
	logic [TIME_W-1:0] entry_time;
	logic [KIND_W-1:0] entry_kind;
	logic              entry_urgent;
	logic [TAG_W-1:0]  entry_tag;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        status;
	logic [TIME_W-1:0] out_time;
	logic [KIND_W-1:0] out_kind;
	logic              out_urgent;
	logic [TAG_W-1:0]  out_tag;
	logic [OCC_W-1:0]  occupancy;

	note_t    held_notes[$];
	outcome_t due_results[$];
	int       mismatches  = 0;
	int       hold_cycles = 0;
	logic     tx_idle     = 1'b1;
	logic     rx_idle     = 1'b1;

	urgent_first_priority_queue_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.entry_time   (entry_time),
		.entry_kind   (entry_kind),
		.entry_urgent (entry_urgent),
		.entry_tag    (entry_tag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_time     (out_time),
		.out_kind     (out_kind),
		.out_urgent   (out_urgent),
		.out_tag      (out_tag),
		.occupancy    (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [1:0] note_rank(input note_t n);
		case (n.kind)
		upq_pkg::KIND_SYSTEM:  return n.urgent ? upq_pkg::RANK_URGENT : upq_pkg::RANK_SYSTEM;
		upq_pkg::KIND_MESSAGE: return upq_pkg::RANK_MESSAGE;
		default:               return upq_pkg::RANK_OTHER;
		endcase
	endfunction

	function automatic logic outranks(input note_t cand, input note_t champ);
		logic cand_hot;
		logic champ_hot;
		cand_hot  = note_rank(cand) == upq_pkg::RANK_URGENT;
		champ_hot = note_rank(champ) == upq_pkg::RANK_URGENT;
		if (cand_hot != champ_hot) return cand_hot;
		if (cand.stamp != champ.stamp) return cand.stamp < champ.stamp;
		return note_rank(cand) > note_rank(champ);
	endfunction

	function automatic void predict_beat(input logic f, input note_t n);
		outcome_t r;
		int       best;
		r = '0;
		if (f == upq_pkg::FUNC_PUSH) begin
			if (held_notes.size() >= DEPTH) begin
				r.st = upq_pkg::ST_FULL;
			end else begin
				held_notes.push_back(n);
				r.st = upq_pkg::ST_PUSHED;
			end
		end else if (held_notes.size() == 0) begin
			r.st = upq_pkg::ST_EMPTY;
		end else begin
			best = 0;
			for (int i = 1; i < held_notes.size(); i++) begin
				if (outranks(held_notes[i], held_notes[best])) best = i;
			end
			r.note = held_notes[best];
			held_notes.delete(best);
			r.st = upq_pkg::ST_POPPED;
		end
		r.occ = OCC_W'(held_notes.size());
		due_results.push_back(r);
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_beat(func, {entry_time, entry_kind, entry_urgent, entry_tag});
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		got = {status, out_time, out_kind, out_urgent, out_tag, occupancy};
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with none expected: status %0d occupancy %0d",
						$realtime, status, occupancy);
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch exp/got status %0d/%0d time %h/%h kind %0d/%0d",
							$realtime, want.st, got.st, want.note.stamp, got.note.stamp,
							want.note.kind, got.note.kind);
						$display("  urgent %0d/%0d tag %h/%h occupancy %0d/%0d",
							want.note.urgent, got.note.urgent, want.note.tag, got.note.tag,
							want.occ, got.occ);
					end
				end
			end
		end
	end

	initial begin
		int wait_cycles;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = hold_cycles > 0 ? hold_cycles : (rx_idle ? $urandom_range(0, 6) : 0);
			hold_cycles = 0;
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_beat(input logic f, input note_t n);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		entry_time   <= n.stamp;
		entry_kind   <= n.kind;
		entry_urgent <= n.urgent;
		entry_tag    <= n.tag;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic note_t random_note();
		note_t n;
		case ($urandom_range(0, 3))
		0:       n.stamp = $urandom_range(0, 7);
		1:       n.stamp = $urandom_range(0, 1) ? '1 : '0;
		default: n.stamp = $urandom();
		endcase
		n.kind   = KIND_W'($urandom_range(0, 3));
		n.urgent = 1'($urandom_range(0, 1));
		n.tag    = TAG_W'($urandom());
		return n;
	endfunction

	task automatic push_note(input logic [TIME_W-1:0] stamp, input logic [KIND_W-1:0] kind,
		input logic urgent, input logic [TAG_W-1:0] tag);
		send_beat(upq_pkg::FUNC_PUSH, {stamp, kind, urgent, tag});
	endtask

	task automatic pop_note();
		send_beat(upq_pkg::FUNC_POP, random_note());
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_and_order();
		pop_note();
		push_note(32'd5, KIND_APP, 1'b1, 16'h0001);
		push_note(32'd5, upq_pkg::KIND_MESSAGE, 1'b1, 16'hFFFF);
		push_note(32'd5, upq_pkg::KIND_SYSTEM, 1'b0, 16'h1234);
		push_note(32'd5, KIND_SPARE, 1'b1, 16'h8000);
		push_note(32'hFFFF_FFFF, upq_pkg::KIND_SYSTEM, 1'b1, 16'h0002);
		push_note(32'd0, KIND_APP, 1'b0, 16'h0003);
		push_note(32'd5, upq_pkg::KIND_MESSAGE, 1'b0, 16'h0004);
		push_note(32'd0, upq_pkg::KIND_SYSTEM, 1'b1, 16'hAAAA);
		push_note(32'd0, upq_pkg::KIND_SYSTEM, 1'b1, 16'h5555);
		repeat (10) pop_note();
		drain_results();
	endtask

	task automatic test_backpressure();
		hold_cycles = 150;
		repeat (DEPTH + 4) send_beat(upq_pkg::FUNC_PUSH, random_note());
		drain_results();
		repeat (DEPTH + 1) pop_note();
		drain_results();
	endtask

	task automatic test_random_traffic(input int count);
		int push_pct;
		push_pct = 50;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				push_pct = $urandom_range(15, 85);
				tx_idle  = $urandom_range(0, 3) != 0;
				rx_idle  = $urandom_range(0, 3) != 0;
			end
			if (n % 175 == 174) drain_results();
			if ($urandom_range(1, 100) <= push_pct)
				send_beat(upq_pkg::FUNC_PUSH, random_note());
			else
				pop_note();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		func         = upq_pkg::FUNC_PUSH;
		entry_time   = '0;
		entry_kind   = upq_pkg::KIND_SYSTEM;
		entry_urgent = 1'b0;
		entry_tag    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_order();
		test_backpressure();
		test_random_traffic(700);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
sv/upq_pkg.sv
sv/upq_cell.sv
sv/urgent_first_priority_queue_unit.sv
dv/tb_urgent_first_priority_queue_unit.sv
